>>> rtl/alb_pkg.sv
// shared types and constants of the backlight ramp controller
`timescale 1ns / 1ps

package alb_pkg;

    localparam int LUX_W      = 16;
    localparam int POS_W      = 4;
    localparam int GAIN_W     = 16;
    localparam int CFG_W      = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_LVL_W  = 10;
    localparam int SCALED_W   = 12;
    localparam int SUM_W      = 13;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd13126;
    localparam logic [CFG_W-1:0]  OFFSET_RESET = 10'd1;
    localparam logic [CFG_W-1:0]  DARK_RESET   = 10'd1;
    localparam logic [CFG_W-1:0]  HYST_RESET   = 10'd10;
    localparam int                LEVEL_RESET  = 127;

    // item kind and dark-level select carried alongside the pipeline
    typedef struct packed {
        logic req;
        logic use_dark;
    } alb_side_t;

endpackage

>>> rtl/alb_log2.sv
// pipelined fixed-point log2 of the lux reading, one fraction bit per stage
`timescale 1ns / 1ps

module alb_log2 import alb_pkg::*; #(
    parameter int LOG_FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  alb_side_t                     in_side,
    input  logic [LUX_W-1:0]              in_lux,
    output logic                          out_valid,
    output alb_side_t                     out_side,
    output logic [POS_W+LOG_FRAC_BITS-1:0] out_log
);

    localparam int F    = LOG_FRAC_BITS;
    localparam int SQ_W = 2 * LUX_W;

    logic                valid_reg [F+1];
    alb_side_t           side_reg  [F+1];
    logic [POS_W-1:0]    pos_reg   [F+1];
    logic [LUX_W-1:0]    mant_reg  [F+1];
    logic [F-1:0]        frac_reg  [F+1];

    logic [POS_W-1:0]    pos_next;
    logic [LUX_W-1:0]    mant_next;

    // leading-one position, bit zero or no bit both give zero
    always_comb begin
        pos_next = '0;
        for (int i = 1; i < LUX_W; i++) begin
            if (in_lux[i]) begin
                pos_next = POS_W'(i);
            end
        end
        mant_next = LUX_W'(in_lux << (POS_W'(LUX_W - 1) - pos_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= in_side;
            pos_reg[0]  <= pos_next;
            mant_reg[0] <= mant_next;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_sq
        logic [SQ_W-1:0]    sq_full;
        logic [LUX_W:0]     sq;

        assign sq_full = SQ_W'(mant_reg[k]) * SQ_W'(mant_reg[k]);
        assign sq      = sq_full[2*LUX_W-1:LUX_W-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        // square reaching 2.0 yields a one bit and is halved
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k+1] <= side_reg[k];
                pos_reg[k+1]  <= pos_reg[k];
                mant_reg[k+1] <= sq[LUX_W] ? sq[LUX_W:1] : sq[LUX_W-1:0];
                frac_reg[k+1] <= {frac_reg[k][F-2:0], sq[LUX_W]};
            end
        end
    end

    assign out_valid = valid_reg[F];
    assign out_side  = side_reg[F];
    assign out_log   = {pos_reg[F], frac_reg[F]};

endmodule

>>> rtl/alb_target.sv
// gain multiply, offset add or dark-level select, and saturation to the target level
`timescale 1ns / 1ps

module alb_target import alb_pkg::*; #(
    parameter int LOG_FRAC_BITS = 8,
    parameter int LEVEL_WIDTH   = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  alb_side_t                      in_side,
    input  logic [POS_W+LOG_FRAC_BITS-1:0] in_log,
    input  logic [GAIN_W-1:0]              log2_gain,
    input  logic [CFG_W-1:0]               level_offset,
    input  logic [CFG_W-1:0]               dark_level,
    output logic                           out_valid,
    output alb_side_t                      out_side,
    output logic [LEVEL_WIDTH-1:0]         out_target
);

    localparam int L_W    = POS_W + LOG_FRAC_BITS;
    localparam int PROD_W = GAIN_W + L_W;
    localparam int SHIFT  = 8 + LOG_FRAC_BITS;
    localparam int TW     = (SUM_W > LEVEL_WIDTH) ? SUM_W : LEVEL_WIDTH;
    localparam logic [TW-1:0] LEVEL_MAX = TW'((1 << LEVEL_WIDTH) - 1);

    logic                   prod_valid_reg;
    alb_side_t              prod_side_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic                   tgt_valid_reg;
    alb_side_t              tgt_side_reg;
    logic [LEVEL_WIDTH-1:0] tgt_reg;

    logic [SCALED_W-1:0]    scaled;
    logic [SUM_W-1:0]       sum;
    logic [TW-1:0]          raw;
    logic [LEVEL_WIDTH-1:0] tgt_next;

    assign scaled = prod_reg[PROD_W-1:SHIFT];
    assign sum    = SUM_W'(scaled) + SUM_W'(level_offset);

    always_comb begin
        raw = prod_side_reg.use_dark ? TW'(dark_level) : TW'(sum);
        if (raw > LEVEL_MAX) begin
            tgt_next = LEVEL_MAX[LEVEL_WIDTH-1:0];
        end else begin
            tgt_next = raw[LEVEL_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            tgt_valid_reg  <= 1'b0;
        end else if (adv) begin
            prod_valid_reg <= in_valid;
            tgt_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_side_reg <= in_side;
            prod_reg      <= PROD_W'(log2_gain) * PROD_W'(in_log);
            tgt_side_reg  <= prod_side_reg;
            tgt_reg       <= tgt_next;
        end
    end

    assign out_valid  = tgt_valid_reg;
    assign out_side   = tgt_side_reg;
    assign out_target = tgt_reg;

endmodule

>>> rtl/alb_ramp.sv
// level, target and ramp state with the result register
`timescale 1ns / 1ps

module alb_ramp import alb_pkg::*; #(
    parameter int LEVEL_WIDTH = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  alb_side_t              in_side,
    input  logic [LEVEL_WIDTH-1:0] in_target,
    input  logic [CFG_W-1:0]       hysteresis_threshold,
    output logic                   out_valid,
    output logic [OUT_LVL_W-1:0]   out_level,
    output logic                   out_busy,
    output logic                   out_changed
);

    localparam int CW = (LEVEL_WIDTH > CFG_W) ? LEVEL_WIDTH : CFG_W;

    logic [LEVEL_WIDTH-1:0] level_reg, level_next;
    logic [LEVEL_WIDTH-1:0] target_reg, target_next;
    logic                   ramp_reg, ramp_next;
    logic                   changed_next;
    logic                   out_valid_reg;
    logic [OUT_LVL_W-1:0]   out_level_reg;
    logic                   out_busy_reg;
    logic                   out_changed_reg;
    logic [LEVEL_WIDTH-1:0] diff;

    assign diff = (in_target > level_reg) ? in_target - level_reg : level_reg - in_target;

    always_comb begin
        level_next   = level_reg;
        target_next  = target_reg;
        ramp_next    = ramp_reg;
        changed_next = 1'b0;
        if (in_side.req == REQ_SAMPLE) begin
            // samples are ignored while a ramp runs
            if (!ramp_reg) begin
                target_next = in_target;
                if (diff != '0 && CW'(diff) >= CW'(hysteresis_threshold)) begin
                    ramp_next = 1'b1;
                end
            end
        end else if (ramp_reg) begin
            if (level_reg < target_reg) begin
                level_next = level_reg + LEVEL_WIDTH'(1);
            end else if (level_reg > target_reg) begin
                level_next = level_reg - LEVEL_WIDTH'(1);
            end
            changed_next = 1'b1;
            if (level_next == target_reg) begin
                ramp_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= LEVEL_WIDTH'(LEVEL_RESET);
            target_reg    <= LEVEL_WIDTH'(LEVEL_RESET);
            ramp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
            if (in_valid) begin
                level_reg  <= level_next;
                target_reg <= target_next;
                ramp_reg   <= ramp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            out_level_reg   <= OUT_LVL_W'(level_next);
            out_busy_reg    <= ramp_next;
            out_changed_reg <= changed_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_level   = out_level_reg;
    assign out_busy    = out_busy_reg;
    assign out_changed = out_changed_reg;

endmodule

>>> rtl/ambient_light_backlight_ramp_core.sv
// top level of the ambient-light backlight ramp controller
`timescale 1ns / 1ps

// Takes one item per clock and returns one result per item, in order.
// A sample item (tuser 0) maps its lux reading to a target level through a
// fixed-point log2, gain and offset; a tick item (tuser 1) moves the level one
// step toward the target while a ramp runs. The pipeline is a leading-one
// normalize stage, one squaring stage per fraction bit for the log2, the gain
// multiply, the saturating target stage and the state/result register.
// The whole pipeline stalls only while a result waits on m_tready. Write the
// configuration registers only while no transfer is in flight.

module ambient_light_backlight_ramp_core import alb_pkg::*; #(
    parameter int LOG_FRAC_BITS = 8,
    parameter int LEVEL_WIDTH   = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // sample_lux[15:0], person_present[16], zero pad
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // level[9:0], ramp_busy[10], level_changed[11], pad
);

    logic [GAIN_W-1:0] gain_reg;
    logic [CFG_W-1:0]  offset_reg;
    logic [CFG_W-1:0]  dark_reg;
    logic [CFG_W-1:0]  hyst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
            dark_reg   <= DARK_RESET;
            hyst_reg   <= HYST_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_LOG2_GAIN:  gain_reg   <= cfg_wr_data;
                CFG_OFFSET:     offset_reg <= cfg_wr_data[CFG_W-1:0];
                CFG_DARK:       dark_reg   <= cfg_wr_data[CFG_W-1:0];
                CFG_HYSTERESIS: hyst_reg   <= cfg_wr_data[CFG_W-1:0];
                default:        gain_reg   <= gain_reg;
            endcase
        end
    end

    logic      adv;
    logic      out_valid;
    alb_side_t in_side;

    // every stage moves when the result register is free or being drained
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    assign in_side.req      = s_tuser;
    assign in_side.use_dark = (s_tdata[LUX_W-1:0] == '0) || !s_tdata[LUX_W];

    logic                           log_valid;
    alb_side_t                      log_side;
    logic [POS_W+LOG_FRAC_BITS-1:0] log_val;

    alb_log2 #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS)
    ) u_log2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_side  (in_side),
        .in_lux   (s_tdata[LUX_W-1:0]),
        .out_valid(log_valid),
        .out_side (log_side),
        .out_log  (log_val)
    );

    logic                   tgt_valid;
    alb_side_t              tgt_side;
    logic [LEVEL_WIDTH-1:0] tgt_level;

    alb_target #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS),
        .LEVEL_WIDTH  (LEVEL_WIDTH)
    ) u_target (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (log_valid),
        .in_side     (log_side),
        .in_log      (log_val),
        .log2_gain   (gain_reg),
        .level_offset(offset_reg),
        .dark_level  (dark_reg),
        .out_valid   (tgt_valid),
        .out_side    (tgt_side),
        .out_target  (tgt_level)
    );

    logic [OUT_LVL_W-1:0] res_level;
    logic                 res_busy;
    logic                 res_changed;

    alb_ramp #(
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_ramp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .adv                 (adv),
        .in_valid            (tgt_valid),
        .in_side             (tgt_side),
        .in_target           (tgt_level),
        .hysteresis_threshold(hyst_reg),
        .out_valid           (out_valid),
        .out_level           (res_level),
        .out_busy            (res_busy),
        .out_changed         (res_changed)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {4'b0000, res_changed, res_busy, res_level};

endmodule
